// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top RTL file of the cofactor block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/cofm_pkg.sv =====
// Package for the 4x4 cofactor block: widths, sizes and shared types.
// Depends on nothing.
`default_nettype none
package cofm_pkg;
  localparam int ElemW  = 16;
  localparam int CofW   = 50;
  localparam int ElemN  = 16;
  localparam int IdxW   = 4;
  localparam int CntW   = 5;
  localparam int DigitW = 2;
  localparam int ProdW  = 48;
  localparam int Steps  = ElemW / DigitW;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [CofW-1:0]  cof_t;

  // Control to the serial multiplier.
  typedef struct packed {
    logic start;
  } mul_ctl_t;

  // Status from the serial multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;
endpackage
`default_nettype wire

// ===== rtl/cofactor_matrix_4x4.sv =====
// Cofactor matrix of a 4x4 Q8.8 matrix.
// The sixteen elements are loaded one word per handshake on in_*. After the
// sixteenth, the block computes the sixteen cofactors in row-major order and
// sends each one as a word on out_* with its row, column and a last flag.
// Each cofactor takes 9 products (three 2x2 terms of two products each, each
// term followed by an outer product), every product on one shared radix-4
// serial multiplier, which takes a start, steps through the multiplier digits
// and then signals done. An inner product also needs two operand reads and an
// accumulate step, an outer product one read and the accumulate step. Speed is
// set by the serial multiplier and the single read port of the element store.
// in_ready is high while loading; it drops from the sixteenth element until
// the last cofactor has been placed in the result register. A stalled
// out_ready holds the result register; the sequencer then waits with the
// next cofactor until the register is taken. Reset (rst_n low, synchronous)
// clears the load count and the sequencer; the element store is not cleared.
// Depends on cofm_pkg, cofm_ram, cofm_mul and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module cofactor_matrix_4x4 import cofm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic signed [15:0] in_element,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [49:0]     out_cofactor,
  output logic [1:0]             out_row,
  output logic [1:0]             out_col,
  output logic                   out_last
);
  typedef enum logic [2:0] {
    S_LOAD, S_READ, S_WAIT, S_MUL, S_ACC, S_OUT
  } state_t;

  // Term program: for each of 9 products, the minor cells (mr,mc) of the
  // multiplicand source and multiplier. Products come in pairs a*b - c*d
  // for the 2x2 term, then outer m0j * term.
  state_t           state_r;
  logic [CntW-1:0]  cnt_r;
  logic [1:0]       row_r, col_r;
  logic [3:0]       op_r;        // 0..8 product index, 9 while emitting
  logic             rd_ph_r;     // 0: first operand, 1: second
  logic signed [ElemW-1:0] opa_r;
  logic signed [ProdW-1:0] t2_r;   // current 2x2 term
  logic signed [CofW-1:0]  det_r;
  logic signed [CofW-1:0]  res_r;
  logic             res_v_r;
  logic [1:0]       res_row_r, res_col_r;
  logic             res_last_r;
  logic             wait_r;

  logic [IdxW-1:0]  raddr;
  logic [ElemW-1:0] rdata;
  logic             we;
  mul_ctl_t         mctl;
  mul_sts_t         msts;
  logic signed [CofW-1:0] prod;
  logic signed [ProdW-1:0] mcand;

  // Map minor cell to the full-matrix index
  function automatic logic [IdxW-1:0] cell_idx(input logic [1:0] r, input logic [1:0] c,
                                                input logic [1:0] mr, input logic [1:0] mc);
    logic [1:0] fr, fc;
    fr = (mr >= r) ? mr + 2'd1 : mr;
    fc = (mc >= c) ? mc + 2'd1 : mc;
    return {fr, fc};
  endfunction

  // Operand cell for product op, operand ph
  always_comb begin
    logic [1:0] mr, mc;
    mr = 2'd0;
    mc = 2'd0;
    case (op_r)
      4'd0: begin mr = rd_ph_r ? 2'd2 : 2'd1; mc = rd_ph_r ? 2'd2 : 2'd1; end
      4'd1: begin mr = rd_ph_r ? 2'd2 : 2'd1; mc = rd_ph_r ? 2'd1 : 2'd2; end
      4'd2: begin mr = 2'd0; mc = 2'd0; end
      4'd3: begin mr = rd_ph_r ? 2'd2 : 2'd1; mc = rd_ph_r ? 2'd2 : 2'd0; end
      4'd4: begin mr = rd_ph_r ? 2'd2 : 2'd1; mc = rd_ph_r ? 2'd0 : 2'd2; end
      4'd5: begin mr = 2'd0; mc = 2'd1; end
      4'd6: begin mr = rd_ph_r ? 2'd2 : 2'd1; mc = rd_ph_r ? 2'd1 : 2'd0; end
      4'd7: begin mr = rd_ph_r ? 2'd2 : 2'd1; mc = rd_ph_r ? 2'd0 : 2'd1; end
      4'd8: begin mr = 2'd0; mc = 2'd2; end
      default: begin mr = 2'd0; mc = 2'd0; end
    endcase
    raddr = cell_idx(row_r, col_r, mr, mc);
  end

  assign we       = in_valid && in_ready;
  assign in_ready = (state_r == S_LOAD);

  cofm_ram #(.Width(ElemW), .Depth(ElemN)) u_ram (
    .clk(clk), .we(we), .waddr(cnt_r[IdxW-1:0]), .wdata(in_element),
    .raddr(raddr), .rdata(rdata)
  );

  // Outer products multiply the 2x2 term; inner ones take the first operand
  logic outer;
  assign outer = (op_r == 4'd2) || (op_r == 4'd5) || (op_r == 4'd8);
  assign mcand = outer ? t2_r : ProdW'(opa_r);
  assign mctl.start = (state_r == S_MUL) && !msts.busy && !msts.done && !wait_r;

  cofm_mul u_mul (
    .clk(clk), .rst_n(rst_n), .ctl(mctl), .mcand(mcand),
    .mplier(rdata), .sts(msts), .prod(prod)
  );

  // Sequencer: load, read operands, multiply, accumulate, emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      res_v_r <= 1'b0;
      wait_r  <= 1'b0;
    end else begin
      if (res_v_r && out_ready && (state_r != S_OUT)) begin
        res_v_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (we) begin
            if (cnt_r == CntW'(ElemN - 1)) begin
              cnt_r   <= '0;
              row_r   <= '0;
              col_r   <= '0;
              op_r    <= '0;
              rd_ph_r <= 1'b0;
              det_r   <= '0;
              state_r <= S_READ;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        S_READ: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (!outer && !rd_ph_r) begin
            opa_r   <= rdata;
            rd_ph_r <= 1'b1;
            state_r <= S_READ;
          end else begin
            wait_r  <= 1'b0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (mctl.start) begin
            wait_r <= 1'b1;
          end else if (msts.done) begin
            wait_r  <= 1'b0;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          rd_ph_r <= 1'b0;
          state_r <= (op_r == 4'd8) ? S_OUT : S_READ;
          op_r    <= op_r + 1'b1;
          case (op_r)
            4'd0, 4'd3, 4'd6: t2_r <= prod[ProdW-1:0];
            4'd1, 4'd4, 4'd7: t2_r <= t2_r - prod[ProdW-1:0];
            4'd2, 4'd8:       det_r <= det_r + prod;
            4'd5:             det_r <= det_r - prod;
            default:          t2_r <= t2_r;
          endcase
        end
        S_OUT: begin
          if (!res_v_r || out_ready) begin
            res_r      <= (row_r[0] ^ col_r[0]) ? -det_r : det_r;
            res_row_r  <= row_r;
            res_col_r  <= col_r;
            res_last_r <= (row_r == 2'd3) && (col_r == 2'd3);
            res_v_r    <= 1'b1;
            op_r       <= '0;
            det_r      <= '0;
            {row_r, col_r} <= {row_r, col_r} + 4'd1;
            state_r    <= ((row_r == 2'd3) && (col_r == 2'd3)) ? S_LOAD : S_READ;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid    = res_v_r;
  assign out_cofactor = res_r;
  assign out_row      = res_row_r;
  assign out_col      = res_col_r;
  assign out_last     = res_last_r;

  `ASSERT_CLK(a_no_load_busy, clk, rst_n, !(in_ready && msts.busy), "load while multiplying")
  `ASSERT_CLK(a_last_pos, clk, rst_n, !(out_valid && out_last) || (out_row == 2'd3 && out_col == 2'd3), "last flag off corner")
  `ASSERT_CLK(a_hold, clk, rst_n, (out_valid && !out_ready) |=> $stable(out_cofactor), "result changed while stalled")
endmodule
`default_nettype wire

// ===== rtl/cofm_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module cofm_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem_r [Depth];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/cofm_mul.sv =====
// Digit-serial signed multiplier: 48-bit multiplicand times 16-bit multiplier,
// two multiplier bits per cycle (radix-4 shift-add). Depends on cofm_pkg.
`default_nettype none
module cofm_mul import cofm_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire mul_ctl_t                ctl,
  input  wire logic signed [ProdW-1:0] mcand,
  input  wire elem_t                   mplier,
  output mul_sts_t                     sts,
  output logic signed [CofW-1:0]       prod
);
  logic signed [CofW+ElemW-1:0] acc_r, acc_nxt;
  logic signed [CofW+ElemW-1:0] mc_r, mc_nxt;
  logic [ElemW-1:0]             mp_r, mp_nxt;
  logic [$clog2(Steps+1)-1:0]   step_r, step_nxt;
  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic signed [CofW+ElemW-1:0] part;

  // Partial product of one digit; the top digit carries negative weight
  always_comb begin
    logic signed [2:0] dig;
    if (step_r == ($clog2(Steps+1))'(Steps - 1)) begin
      dig = $signed({mp_r[1], mp_r[1:0]});
    end else begin
      dig = $signed({1'b0, mp_r[1:0]});
    end
    part = mc_r * (CofW+ElemW)'(dig);
  end

  // Advance one digit per cycle
  always_comb begin
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      acc_nxt  = '0;
      mc_nxt   = (CofW+ElemW)'(mcand);
      mp_nxt   = mplier;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt  = acc_r + part;
      mc_nxt   = mc_r <<< DigitW;
      mp_nxt   = mp_r >> DigitW;
      step_nxt = step_r + 1'b1;
      if (step_r == ($clog2(Steps+1))'(Steps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r  <= acc_nxt;
    mc_r   <= mc_nxt;
    mp_r   <= mp_nxt;
    step_r <= step_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod     = acc_r[CofW-1:0];
endmodule
`default_nettype wire

// ===== tb/cofactor_matrix_4x4_tb.sv =====
// Testbench for cofactor_matrix_4x4: streams 4x4 Q8.8 matrices and checks the
// sixteen cofactors that follow each one against a local cofactor predictor.
// Depends on cofm_pkg and the cofactor_matrix_4x4 RTL.
`default_nettype none

class cofactor_board;
  logic signed [15:0] elems[16];
  int unsigned fill;
  logic signed [49:0] exp_cof[$];
  logic [1:0] exp_row[$];
  logic [1:0] exp_col[$];
  logic exp_last[$];
  int unsigned mismatches;

  function new();
    fill = 0;
    mismatches = 0;
  endfunction

  // 3x3 determinant of the minor without row r and column c
  function automatic longint minor_det(int r, int c);
    longint m[3][3];
    int mr;
    int mc;
    mr = 0;
    for (int i = 0; i < 4; i++) begin
      if (i == r) continue;
      mc = 0;
      for (int j = 0; j < 4; j++) begin
        if (j == c) continue;
        m[mr][mc] = elems[i*4+j];
        mc++;
      end
      mr++;
    end
    return m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
         - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
         + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
  endfunction

  // Store an accepted word; on the sixteenth queue all cofactors
  function void note_element(logic signed [15:0] e);
    longint d;
    elems[fill] = e;
    fill++;
    if (fill < 16) return;
    fill = 0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        d = minor_det(r, c);
        if ((r + c) % 2 == 1) d = -d;
        exp_cof.push_back(d[49:0]);
        exp_row.push_back(r[1:0]);
        exp_col.push_back(c[1:0]);
        exp_last.push_back(r == 3 && c == 3);
      end
    end
  endfunction

  function void check_cofactor(logic signed [49:0] cof, logic [1:0] row, logic [1:0] col,
                               logic lst);
    logic signed [49:0] ec;
    logic [1:0] er;
    logic [1:0] ecl;
    logic el;
    if (exp_cof.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected cofactor word %0d at (%0d,%0d)", cof, row, col);
      return;
    end
    ec = exp_cof.pop_front();
    er = exp_row.pop_front();
    ecl = exp_col.pop_front();
    el = exp_last.pop_front();
    if (cof !== ec || row !== er || col !== ecl || lst !== el) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp cof=%0d r=%0d c=%0d l=%0b, got cof=%0d r=%0d c=%0d l=%0b",
                 ec, er, ecl, el, cof, row, col, lst);
    end
  endfunction

  function int pending();
    return exp_cof.size();
  endfunction
endclass

module cofactor_matrix_4x4_tb;
  import cofm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_element = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [49:0] out_cofactor;
  logic [1:0] out_row;
  logic [1:0] out_col;
  logic out_last;

  cofactor_board board = new();
  int unsigned cycles = 0;
  int unsigned stall_mode = 0;

  cofactor_matrix_4x4 dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_element(in_element),
    .out_valid(out_valid), .out_ready(out_ready), .out_cofactor(out_cofactor),
    .out_row(out_row), .out_col(out_col), .out_last(out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, sometimes none
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drop valid for the gap, then offer one word and hold it until accepted
  task automatic send_element(logic signed [15:0] e);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_element <= e;
    do @(posedge clk); while (!in_ready);
    board.note_element(e);
  endtask

  function automatic logic signed [15:0] rand_element(int kind);
    case (kind)
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 15) - 8);
      3: return {8'($urandom_range(0, 255)), 8'h00};
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Result side: random stalls, sample at the edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_cofactor(out_cofactor, out_row, out_col, out_last);
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_mode == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) < (stall_mode == 1 ? 70 : 10));
    end
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
  end

  // Watchdog and end of run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: extremes, zeros, identity-like
    for (int i = 0; i < 16; i++) send_element(i[0] ? 16'sh8000 : 16'sh7fff);
    for (int i = 0; i < 16; i++) send_element((i % 5 == 0) ? 16'sh0100 : 16'sh0000);
    // Random matrices, 192 words
    for (int m = 0; m < 12; m++) begin
      int kind;
      kind = $urandom_range(0, 4);
      for (int i = 0; i < 16; i++)
        send_element(rand_element($urandom_range(0, 3) == 0 ? $urandom_range(0, 4) : kind));
    end
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/cofm_pkg.sv
rtl/cofm_ram.sv
rtl/cofm_mul.sv
rtl/cofactor_matrix_4x4.sv
tb/cofactor_matrix_4x4_tb.sv
